FILE: hdl/ilbm_body_byterun_decoder_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ILBM_BODY_BYTERUN_DECODER_MACROS_SVH
`define ILBM_BODY_BYTERUN_DECODER_MACROS_SVH

// Same-cycle implication.
`define IBBD_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define IBBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ibbd_pkg.sv
package ibbd_pkg;

   localparam int DEF_OFFSET_BITS   = 24;
   localparam int DEF_MAX_ROW_BYTES = 4096;
   localparam int MAX_PLANES        = 25;

   localparam int OUT_OFFSET_W = 24;
   localparam int CSR_DATA_W   = 25;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [7:0] RLE_NOP       = 8'h80;
   localparam logic [7:0] RLE_LIT_LIMIT = 8'h80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMPRESSION     = 3'd0,
      CSR_ROW_BYTES       = 3'd1,
      CSR_PLANE_COUNT     = 3'd2,
      CSR_DEST_PLANES     = 3'd3,
      CSR_PLANE_ENABLE    = 3'd4,
      CSR_ROW_LIMIT       = 3'd5,
      CSR_DEST_ROW_STRIDE = 3'd6,
      CSR_START_OFFSET    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        compression;
      logic [12:0] row_bytes;
      logic [4:0]  plane_count;
      logic [4:0]  dest_planes;
      logic [24:0] plane_enable;
      logic [12:0] row_limit;
      logic [13:0] dest_row_stride;
      logic [23:0] start_offset;
   } cfg_type;

   typedef struct packed {
      logic [4:0]              plane_index;
      logic [OUT_OFFSET_W-1:0] byte_offset;
      logic [7:0]              fill_value;
      logic [7:0]              repeat_res;
      logic                    image_done;
   } rsp_beat_type;

endpackage

FILE: hdl/ibbd_walker.sv
`include "ilbm_body_byterun_decoder_macros.svh"

module ibbd_walker
   import ibbd_pkg::*;
#(
   parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
   parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         accept,
   input  logic [7:0]   src_byte,
   input  logic         first,
   output logic         res_valid,
   output rsp_beat_type res
);

   // a packet may run up to 128 bytes past the row end
   localparam int COL_W = $clog2(MAX_ROW_BYTES + 128);

   logic [12:0]            row_ff, row_in, eff_row;
   logic [4:0]             plane_ff, plane_in, eff_plane;
   logic [COL_W-1:0]       col_ff, col_in, eff_col, col_new;
   logic [OFFSET_BITS-1:0] base_ff, base_in, eff_base, offset_w;
   logic [7:0]             lit_ff, lit_in, eff_lit;
   logic [7:0]             run_ff, run_in, eff_run;
   logic                   fin_ff, fin_in, eff_fin;

   logic [12:0] rb_eff;
   logic        skip;
   logic        emit;
   logic        pend;
   logic        done;
   logic        writable;
   logic [7:0]  rep;
   logic [5:0]  plane_next;
   logic [31:0] en_sh;

   // a first beat restarts the walk before the byte is decoded
   assign eff_row   = first ? '0 : row_ff;
   assign eff_plane = first ? '0 : plane_ff;
   assign eff_col   = first ? '0 : col_ff;
   assign eff_lit   = first ? '0 : lit_ff;
   assign eff_run   = first ? '0 : run_ff;
   assign eff_fin   = first ? 1'b0 : fin_ff;
   assign eff_base  = first ? OFFSET_BITS'(32'(cfg.start_offset)) : base_ff;

   assign rb_eff = (32'(cfg.row_bytes) > 32'(MAX_ROW_BYTES)) ? 13'(MAX_ROW_BYTES)
                                                            : cfg.row_bytes;

   assign skip = eff_fin || (rb_eff == '0) || (cfg.plane_count == '0) ||
                 (eff_row >= cfg.row_limit);

   assign offset_w = eff_base + OFFSET_BITS'(eff_col);

   assign en_sh    = 32'(cfg.plane_enable) >> eff_plane;
   assign writable = ({1'b0, eff_plane} < {1'b0, cfg.dest_planes}) &&
                     ({1'b0, eff_plane} < 6'(MAX_PLANES)) &&
                     (!cfg.compression || en_sh[0]);

   always_comb begin
      row_in     = eff_row;
      plane_in   = eff_plane;
      col_in     = eff_col;
      base_in    = eff_base;
      lit_in     = eff_lit;
      run_in     = eff_run;
      fin_in     = eff_fin;
      emit       = 1'b0;
      pend       = 1'b0;
      done       = 1'b0;
      rep        = '0;
      col_new    = eff_col;
      plane_next = '0;
      if (!skip) begin
         if (!cfg.compression) begin
            // raw rows: drop any packet state left from run-length mode
            lit_in = '0;
            run_in = '0;
            emit   = 1'b1;
            rep    = 8'd1;
            pend   = 1'b1;
         end else if (eff_run != '0) begin
            emit   = 1'b1;
            rep    = eff_run;
            run_in = '0;
            pend   = 1'b1;
         end else if (eff_lit != '0) begin
            emit   = 1'b1;
            rep    = 8'd1;
            lit_in = eff_lit - 8'd1;
            pend   = (eff_lit == 8'd1);
         end else if (src_byte < RLE_LIT_LIMIT) begin
            lit_in = src_byte + 8'd1;
         end else if (src_byte != RLE_NOP) begin
            run_in = 8'(9'd257 - {1'b0, src_byte});
         end
         col_new = eff_col + COL_W'(rep);
         col_in  = col_new;
         if (pend && (32'(col_new) >= 32'(rb_eff))) begin
            col_in     = '0;
            plane_next = {1'b0, eff_plane} + 6'd1;
            if (plane_next >= {1'b0, cfg.plane_count}) begin
               plane_in = '0;
               row_in   = eff_row + 13'd1;
               base_in  = eff_base + OFFSET_BITS'(cfg.dest_row_stride);
               if (row_in >= cfg.row_limit) begin
                  fin_in = 1'b1;
                  done   = 1'b1;
               end
            end else begin
               plane_in = plane_next[4:0];
            end
         end
      end
   end

   always_comb begin
      res_valid = (emit && writable) || done;
      if (emit && writable) begin
         res.plane_index = eff_plane;
         res.byte_offset = OUT_OFFSET_W'(32'(offset_w));
         res.fill_value  = src_byte;
         res.repeat_res  = rep;
      end else begin
         // done marker: no write, fields zero but image_done
         res.plane_index = '0;
         res.byte_offset = '0;
         res.fill_value  = '0;
         res.repeat_res  = '0;
      end
      res.image_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         plane_ff <= '0;
         col_ff   <= '0;
         base_ff  <= '0;
         lit_ff   <= '0;
         run_ff   <= '0;
         fin_ff   <= 1'b0;
      end else if (accept) begin
         row_ff   <= row_in;
         plane_ff <= plane_in;
         col_ff   <= col_in;
         base_ff  <= base_in;
         lit_ff   <= lit_in;
         run_ff   <= run_in;
         fin_ff   <= fin_in;
      end
   end

   `IBBD_ASSERT_HOLDS(a_zero_repeat_is_marker, clock, reset,
      accept && res_valid && (res.repeat_res == 8'd0), res.image_done,
      "result without write must be the done marker")
   `IBBD_ASSERT_NEXT(a_done_sets_finished, clock, reset,
      accept && done, fin_ff && (row_ff == cfg.row_limit),
      "last row completed but walk not finished")
   `IBBD_ASSERT_HOLDS(a_run_or_literals, clock, reset,
      1'b1, (run_ff == 8'd0) || (lit_ff == 8'd0),
      "run and literal packet pending together")

endmodule

FILE: hdl/ibbd_rsp_queue.sv
`include "ilbm_body_byterun_decoder_macros.svh"

module ibbd_rsp_queue
   import ibbd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_beat_type push_beat,
   output logic         full,
   output logic         out_valid,
   output rsp_beat_type out_beat,
   input  logic         pop
);

   rsp_beat_type slot_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_beat  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `IBBD_ASSERT_HOLDS(a_count_bounded, clock, reset,
      1'b1, count_ff <= 2'd2, "result queue count out of range")
   `IBBD_ASSERT_HOLDS(a_no_push_when_full, clock, reset,
      full, !push, "beat pushed into full result queue")
   `IBBD_ASSERT_NEXT(a_fill_to_full, clock, reset,
      push && !pop && (count_ff == 2'd1), full,
      "queue did not fill on second beat")

endmodule

FILE: hdl/ilbm_body_byterun_decoder.sv
// A result beat is registered in the result queue when its source byte is accepted and is presented from there on rsp_.
// Throughput: one source byte per cycle while req_stall is low; each byte is decoded in the cycle it is taken.
// A two-beat result queue sets the limit: req_stall rises only while two beats wait.
// Reset: synchronous, active high; registers return to their defaults (ByteRun1,
// row_bytes 2, one plane) and the walk state and result queue are cleared.
module ilbm_body_byterun_decoder
   import ibbd_pkg::*;
#(
   parameter int OFFSET_BITS   = DEF_OFFSET_BITS,
   parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_src_byte,
   input  logic                    req_first,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [4:0]              rsp_plane_index,
   output logic [OUT_OFFSET_W-1:0] rsp_byte_offset,
   output logic [7:0]              rsp_fill_value,
   output logic [7:0]              rsp_repeat_res,
   output logic                    rsp_image_done
);

   cfg_type      csr_ff, csr_in;
   logic         accept;
   logic         res_valid;
   rsp_beat_type res;
   logic         q_full;
   rsp_beat_type out_beat;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_COMPRESSION:     csr_in.compression     = csr_wdata[0];
            CSR_ROW_BYTES:       csr_in.row_bytes       = csr_wdata[12:0];
            CSR_PLANE_COUNT:     csr_in.plane_count     = csr_wdata[4:0];
            CSR_DEST_PLANES:     csr_in.dest_planes     = csr_wdata[4:0];
            CSR_PLANE_ENABLE:    csr_in.plane_enable    = csr_wdata[24:0];
            CSR_ROW_LIMIT:       csr_in.row_limit       = csr_wdata[12:0];
            CSR_DEST_ROW_STRIDE: csr_in.dest_row_stride = csr_wdata[13:0];
            CSR_START_OFFSET:    csr_in.start_offset    = csr_wdata[23:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.compression     <= 1'b1;
         csr_ff.row_bytes       <= 13'd2;
         csr_ff.plane_count     <= 5'd1;
         csr_ff.dest_planes     <= '0;
         csr_ff.plane_enable    <= '0;
         csr_ff.row_limit       <= '0;
         csr_ff.dest_row_stride <= '0;
         csr_ff.start_offset    <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   ibbd_walker #(
      .OFFSET_BITS   (OFFSET_BITS),
      .MAX_ROW_BYTES (MAX_ROW_BYTES)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (csr_ff),
      .accept    (accept),
      .src_byte  (req_src_byte),
      .first     (req_first),
      .res_valid (res_valid),
      .res       (res)
   );

   ibbd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res_valid),
      .push_beat (res),
      .full      (q_full),
      .out_valid (rsp_valid),
      .out_beat  (out_beat),
      .pop       (rsp_valid && !rsp_stall)
   );

   assign rsp_plane_index = out_beat.plane_index;
   assign rsp_byte_offset = out_beat.byte_offset;
   assign rsp_fill_value  = out_beat.fill_value;
   assign rsp_repeat_res  = out_beat.repeat_res;
   assign rsp_image_done  = out_beat.image_done;

endmodule

FILE: tb/tb.sv
module tb;
   import ibbd_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int TARGET_BYTES = 650;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY_THIRD} stall_style_type;

   // Mirror of the decoder walk plus the queue of write descriptors still owed.
   class descriptor_scoreboard;
      cfg_type      regs;
      bit [12:0]    row_cnt;
      bit [4:0]     plane_cnt;
      bit [12:0]    column;
      bit [23:0]    row_base;
      bit [7:0]     literals_due;
      bit [7:0]     run_due;
      bit           body_done;
      rsp_beat_type due_writes[$];
      int           mismatches;
      int           beats_seen;
      int           markers_due;

      function new();
         regs             = '0;
         regs.compression = 1'b1;
         regs.row_bytes   = 13'd2;
         regs.plane_count = 5'd1;
         restart_walk();
         row_base    = '0;
         mismatches  = 0;
         beats_seen  = 0;
         markers_due = 0;
      endfunction

      function void restart_walk();
         row_cnt      = '0;
         plane_cnt    = '0;
         column       = '0;
         literals_due = '0;
         run_due      = '0;
         body_done    = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_COMPRESSION:     regs.compression     = value[0];
            CSR_ROW_BYTES:       regs.row_bytes       = value[12:0];
            CSR_PLANE_COUNT:     regs.plane_count     = value[4:0];
            CSR_DEST_PLANES:     regs.dest_planes     = value[4:0];
            CSR_PLANE_ENABLE:    regs.plane_enable    = value[24:0];
            CSR_ROW_LIMIT:       regs.row_limit       = value[12:0];
            CSR_DEST_ROW_STRIDE: regs.dest_row_stride = value[13:0];
            CSR_START_OFFSET:    regs.start_offset    = value[23:0];
            default: ;
         endcase
      endfunction

      // Advance the walk by one accepted byte; returns 0 when the byte is ignored.
      function bit decode_byte(bit [7:0] src, bit first);
         bit [12:0]    span;
         bit [23:0]    offset;
         bit [7:0]     count;
         bit [4:0]     plane_now;
         bit           emit;
         bit           packet_end;
         bit           last_row;
         bit           writable;
         rsp_beat_type beat;
         emit       = 1'b0;
         packet_end = 1'b0;
         last_row   = 1'b0;
         count      = '0;
         if (first) begin
            restart_walk();
            row_base = regs.start_offset;
         end
         span = (regs.row_bytes > DEF_MAX_ROW_BYTES) ? 13'(DEF_MAX_ROW_BYTES) : regs.row_bytes;
         if (body_done || span == 0 || regs.plane_count == 0 || row_cnt >= regs.row_limit)
            return 1'b0;
         offset    = row_base + 24'(column);
         plane_now = plane_cnt;
         if (!regs.compression) begin
            // raw rows: any half-read packet is dropped
            literals_due = '0;
            run_due      = '0;
            emit         = 1'b1;
            count        = 8'd1;
            column       = column + 13'd1;
            packet_end   = 1'b1;
         end else if (run_due != 0) begin
            emit       = 1'b1;
            count      = run_due;
            column     = column + 13'(run_due);
            run_due    = '0;
            packet_end = 1'b1;
         end else if (literals_due != 0) begin
            emit         = 1'b1;
            count        = 8'd1;
            column       = column + 13'd1;
            literals_due = literals_due - 8'd1;
            packet_end   = (literals_due == 0);
         end else if (src < RLE_LIT_LIMIT) begin
            literals_due = src + 8'd1;
         end else if (src != RLE_NOP) begin
            run_due = 8'(9'd257 - 9'(src));
         end
         writable = (plane_now < regs.dest_planes) && (plane_now < MAX_PLANES);
         if (writable && regs.compression)
            writable = regs.plane_enable[plane_now];
         if (packet_end && column >= span) begin
            column    = '0;
            plane_cnt = plane_cnt + 5'd1;
            if (plane_cnt >= regs.plane_count) begin
               plane_cnt = '0;
               row_cnt   = row_cnt + 13'd1;
               row_base  = row_base + 24'(regs.dest_row_stride);
               if (row_cnt >= regs.row_limit) begin
                  body_done = 1'b1;
                  last_row  = 1'b1;
               end
            end
         end
         if (emit && writable) begin
            beat.plane_index = plane_now;
            beat.byte_offset = offset;
            beat.fill_value  = src;
            beat.repeat_res  = count;
            beat.image_done  = last_row;
            due_writes.push_back(beat);
         end else if (last_row) begin
            beat            = '0;
            beat.image_done = 1'b1;
            due_writes.push_back(beat);
            markers_due++;
         end
         return 1'b1;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at beat %0d: %s", beats_seen, what);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %h, predicted %h", name, got, want));
      endtask

      task check_beat(rsp_beat_type got);
         rsp_beat_type want;
         beats_seen++;
         if (due_writes.size() == 0) begin
            report_mismatch($sformatf("unpredicted beat plane %0d offset %h value %h rep %0d",
                                      got.plane_index, got.byte_offset, got.fill_value,
                                      got.repeat_res));
            return;
         end
         want = due_writes.pop_front();
         compare_field("plane_index", 32'(got.plane_index), 32'(want.plane_index));
         compare_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
         compare_field("fill_value",  32'(got.fill_value),  32'(want.fill_value));
         compare_field("repeat_res",  32'(got.repeat_res),  32'(want.repeat_res));
         compare_field("image_done",  32'(got.image_done),  32'(want.image_done));
      endtask

      task flush();
         if (due_writes.size() != 0)
            report_mismatch($sformatf("%0d predicted beats never arrived", due_writes.size()));
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   csr_index_type           csr_index = CSR_COMPRESSION;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [7:0]              req_src_byte = '0;
   logic                    req_first = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [4:0]              rsp_plane_index;
   logic [OUT_OFFSET_W-1:0] rsp_byte_offset;
   logic [7:0]              rsp_fill_value;
   logic [7:0]              rsp_repeat_res;
   logic                    rsp_image_done;

   descriptor_scoreboard sb;
   bit [7:0]             body_q[$];
   int unsigned          cycle_count = 0;
   int                   bytes_sent = 0;
   int                   decoded_bytes = 0;
   int                   settings_loaded = 0;
   stall_style_type      stall_style = STALL_NONE;
   rsp_beat_type         seen_beat;

   ilbm_body_byterun_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_src_byte    (req_src_byte),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_plane_index (rsp_plane_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_fill_value  (rsp_fill_value),
      .rsp_repeat_res  (rsp_repeat_res),
      .rsp_image_done  (rsp_image_done)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver: check the beat taken at this edge, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_beat = {rsp_plane_index, rsp_byte_offset, rsp_fill_value, rsp_repeat_res,
                      rsp_image_done};
         sb.check_beat(seen_beat);
      end
      if (cycle_count % 64 == 0)
         stall_style = stall_style_type'($urandom_range(0, 3));
      case (stall_style)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 4) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (cycle_count % 3 == 0);
      endcase
   end

   task automatic send_byte(bit [7:0] src, bit first);
      req_valid    <= 1'b1;
      req_src_byte <= src;
      req_first    <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (sb.decode_byte(src, first))
         decoded_bytes++;
   endtask

   // Hold the sender until every predicted beat is out, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due_writes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] value, int width);
      bit [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      junk = $urandom_range(0, 1) ? (junk << width) : '0;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value | junk;
      @(posedge clock);
      sb.write_reg(idx, value | junk);
   endtask

   task automatic load_regs(cfg_type c);
      put_reg(CSR_COMPRESSION,     25'(c.compression),     1);
      put_reg(CSR_ROW_BYTES,       25'(c.row_bytes),       13);
      put_reg(CSR_PLANE_COUNT,     25'(c.plane_count),     5);
      put_reg(CSR_DEST_PLANES,     25'(c.dest_planes),     5);
      put_reg(CSR_PLANE_ENABLE,    25'(c.plane_enable),    25);
      put_reg(CSR_ROW_LIMIT,       25'(c.row_limit),       13);
      put_reg(CSR_DEST_ROW_STRIDE, 25'(c.dest_row_stride), 14);
      put_reg(CSR_START_OFFSET,    25'(c.start_offset),    24);
      csr_wr_en <= 1'b0;
      settings_loaded++;
   endtask

   function automatic cfg_type pick_settings();
      cfg_type     c;
      int unsigned shape;
      int unsigned pick;
      c.compression = ($urandom_range(0, 3) != 0);
      c.row_bytes   = 13'(2 * $urandom_range(1, 8));
      c.plane_count = 5'($urandom_range(1, 6));
      c.row_limit   = 13'($urandom_range(1, 3));
      shape = $urandom_range(0, 19);
      if (shape == 0) begin
         // wide rows, filled with long runs
         c.compression = 1'b1;
         c.row_bytes   = $urandom_range(0, 1) ? 13'(DEF_MAX_ROW_BYTES) : 13'h1FFF;
         c.plane_count = 5'd1;
         c.row_limit   = 13'd1;
      end else if (shape == 1) begin
         c.plane_count = $urandom_range(0, 1) ? 5'(MAX_PLANES) : 5'h1F;
         c.row_bytes   = 13'd2;
         c.row_limit   = 13'd1;
      end else if (shape == 2) begin
         c.row_bytes = 13'($urandom_range(0, 9));
      end else if (shape == 3) begin
         c.plane_count = '0;
      end else if (shape == 4) begin
         pick = $urandom_range(0, 2);
         c.row_limit = (pick == 0) ? 13'd0 : (pick == 1) ? 13'(DEF_MAX_ROW_BYTES) : 13'h1FFF;
      end
      pick = $urandom_range(0, 9);
      c.dest_planes = (pick == 0) ? 5'd0 : (pick == 1) ? 5'(MAX_PLANES) : (pick == 2) ? 5'h1F :
                      5'($urandom_range(0, c.plane_count + 1));
      pick = $urandom_range(0, 5);
      c.plane_enable = (pick == 0) ? '0 : (pick == 1) ? '1 : 25'($urandom);
      pick = $urandom_range(0, 5);
      c.dest_row_stride = (pick == 0) ? 14'd0 : (pick == 1) ? 14'd8192 : (pick == 2) ? 14'h3FFF :
                          14'($urandom);
      pick = $urandom_range(0, 5);
      c.start_offset = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
                       (pick == 2) ? 24'hFFFFFF - 24'($urandom_range(0, 40)) : 24'($urandom);
      return c;
   endfunction

   // Build a well-formed body for these settings, with a little noise and truncation.
   task automatic build_body(cfg_type c);
      int span;
      int rows;
      int col;
      int n;
      int kind;
      int cut;
      body_q.delete();
      span = (c.row_bytes > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : int'(c.row_bytes);
      if (span == 0 || c.plane_count == 0 || c.row_limit == 0) begin
         repeat (4) body_q.push_back(8'($urandom));
         return;
      end
      rows = (c.row_limit < 3) ? int'(c.row_limit) : 3;
      for (int r = 0; r < rows; r++) begin
         for (int p = 0; p < c.plane_count; p++) begin
            col = 0;
            while (col < span) begin
               if (!c.compression) begin
                  body_q.push_back(8'($urandom));
                  col++;
               end else begin
                  kind = $urandom_range(0, 9);
                  n = $urandom_range(1, (span - col < 128) ? span - col : 128);
                  if (span - col > 256) begin
                     kind = 9;
                     n    = 128;
                  end
                  // overshoot the row end now and then
                  if ($urandom_range(0, 7) == 0)
                     n = (n + $urandom_range(0, 4) > 128) ? 128 : n + $urandom_range(0, 4);
                  if (kind == 0) begin
                     body_q.push_back(RLE_NOP);
                  end else if (kind < 5) begin
                     body_q.push_back(8'(n - 1));
                     repeat (n) body_q.push_back(8'($urandom));
                     col += n;
                  end else begin
                     if (n < 2) n = 2;
                     body_q.push_back(8'(257 - n));
                     body_q.push_back(8'($urandom));
                     col += n;
                  end
               end
               if ($urandom_range(0, 199) == 0)
                  body_q.push_back(8'($urandom));
            end
         end
      end
      if ($urandom_range(0, 5) == 0) begin
         cut = $urandom_range(1, body_q.size());
         while (body_q.size() > cut) void'(body_q.pop_back());
      end
      repeat ($urandom_range(0, 2)) body_q.push_back(8'($urandom));
   endtask

   task automatic send_body(bit with_first, bit no_idle, bit drain_midway);
      int unsigned burst;
      bit          first;
      burst = $urandom_range(1, 24);
      foreach (body_q[i]) begin
         first = (i == 0 && with_first) || ($urandom_range(0, 149) == 0);
         send_byte(body_q[i], first);
         if (drain_midway && i == body_q.size() / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.due_writes.size() != 0);
         end else if (!no_idle) begin
            burst -= 1;
            if (burst == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
               burst = $urandom_range(1, 24);
            end
         end
      end
   endtask

   initial begin
      cfg_type     settings;
      int unsigned waited;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings, no body start yet: row_limit is 0 after reset, so the walk ignores the byte
      send_byte(8'h05, 1'b0);
      settle();

      // ByteRun1: literals, a long run past row end, no-op, disabled and missing planes,
      // offset wrap, and an image that ends on a skipped plane
      settings = '{compression: 1'b1, row_bytes: 13'd4, plane_count: 5'd3, dest_planes: 5'd2,
                   plane_enable: 25'h1, row_limit: 13'd2, dest_row_stride: 14'h3FFF,
                   start_offset: 24'hFFFFFE};
      load_regs(settings);
      body_q = '{8'h01, 8'h00, 8'hFF, 8'h81, 8'hAA,
                 8'h80, 8'hFF, 8'h55, 8'hFE, 8'h11,
                 8'h03, 8'h12, 8'h34, 8'h56, 8'h78,
                 8'h83, 8'h3C, 8'hFD, 8'h01, 8'h81, 8'h77,
                 8'h00};
      send_body(1'b1, 1'b1, 1'b0);
      settle();

      // raw rows: last byte writes and completes the image
      settings = '{compression: 1'b0, row_bytes: 13'd2, plane_count: 5'd1,
                   dest_planes: 5'(MAX_PLANES), plane_enable: 25'h0, row_limit: 13'd1,
                   dest_row_stride: 14'd0, start_offset: 24'd0};
      load_regs(settings);
      body_q = '{8'h00, 8'hFF};
      send_body(1'b1, 1'b1, 1'b0);

      while (bytes_sent < TARGET_BYTES) begin
         settings = pick_settings();
         settle();
         load_regs(settings);
         build_body(settings);
         send_body(($urandom_range(0, 4) != 0), ($urandom_range(0, 3) == 0),
                   (settings_loaded == 3) || ($urandom_range(0, 9) == 0));
      end

      req_valid <= 1'b0;
      waited = 0;
      while (sb.due_writes.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (5) @(posedge clock);
      sb.flush();

      $display("sent %0d body bytes (%0d decoded) under %0d register settings",
               bytes_sent, decoded_bytes, settings_loaded);
      $display("checked %0d descriptor beats, %0d of them image-done markers",
               sb.beats_seen, sb.markers_due);
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
